/* rtl/fwdf_pkg.sv */
package fwdf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NDIG = 6;
	localparam int BCDW = 4 * NDIG;

	localparam logic [3:0] KIND_U2     = 4'd0;
	localparam logic [3:0] KIND_I3     = 4'd1;
	localparam logic [3:0] KIND_ILEFT  = 4'd2;
	localparam logic [3:0] KIND_I4     = 4'd3;
	localparam logic [3:0] KIND_F3_2U  = 4'd4;
	localparam logic [3:0] KIND_F5_2   = 4'd5;
	localparam logic [3:0] KIND_F3_1   = 4'd6;
	localparam logic [3:0] KIND_F4_1S  = 4'd7;
	localparam logic [3:0] KIND_F1_3   = 4'd8;
	localparam logic [3:0] KIND_I5     = 4'd9;
	localparam logic [3:0] KIND_F5_1S  = 4'd10;
	localparam logic [3:0] KIND_F5_2S  = 4'd11;
	localparam logic [3:0] KIND_F6_2U  = 4'd12;
	localparam logic [3:0] KIND_F5_2P  = 4'd13;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_BLANK = 8'h20;

	typedef struct packed {
		logic [3:0] kind;
		logic       neg;
		logic       fb;
		logic       nz;
		logic       ge10;
		logic       ge100;
		logic       ge1000;
		logic       ge10000;
		logic       ge100000;
		logic [7:0] plus_char;
	} ctl_t;

	// one double-dabble step on six BCD digits; carries out of the top digit drop
	function automatic logic [BCDW-1:0] dd_step(input logic [BCDW-1:0] b, input logic bin);
		logic [BCDW-1:0] t;
		t = b;
		for (int i = 0; i < NDIG; i++) begin
			if (t[4*i +: 4] >= 4'd5) t[4*i +: 4] = t[4*i +: 4] + 4'd3;
		end
		return {t[BCDW-2:0], bin};
	endfunction

	function automatic logic [7:0] ch(input logic [3:0] d);
		return CH_ZERO + {4'd0, d};
	endfunction

endpackage

/* rtl/fwdf_scale.sv */
module fwdf_scale #(
	parameter int FRAC_BITS = fwdf_pkg::FRAC_BITS_DEF,
	parameter int PW = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [3:0]          kind,
	input  logic signed [31:0]  value,
	input  logic [7:0]          plus_char,
	output logic                out_vld,
	output logic [PW-1:0]       m_out,
	output fwdf_pkg::ctl_t      ctl_out
);
	localparam int MW = 42 - FRAC_BITS;

	logic             vld_s1, vld_s2, vld_s3;
	logic [31:0]      mag_s1;
	logic             sgn_s1, sgn_s2;
	logic [3:0]       kind_s1, kind_s2;
	logic [7:0]       plus_s1, plus_s2;
	logic [MW-1:0]    p1_s2, p10_s2, p100_s2, p1000_s2;
	logic [PW-1:0]    m_s3;
	fwdf_pkg::ctl_t   ctl_s3;

	logic [41:0] magw, pr10, pr100, pr1000;
	assign magw   = {10'd0, mag_s1};
	assign pr10   = magw * 42'd10;
	assign pr100  = magw * 42'd100;
	assign pr1000 = magw * 42'd1000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s1   <= value[31];
		mag_s1   <= value[31] ? (~value + 32'd1) : value;
		kind_s1  <= kind;
		plus_s1  <= plus_char;
		sgn_s2   <= sgn_s1;
		kind_s2  <= kind_s1;
		plus_s2  <= plus_s1;
		p1_s2    <= MW'(magw >> FRAC_BITS);
		p10_s2   <= MW'(pr10 >> FRAC_BITS);
		p100_s2  <= MW'(pr100 >> FRAC_BITS);
		p1000_s2 <= MW'(pr1000 >> FRAC_BITS);
	end

	logic [MW-1:0] msel;
	logic          fb, n10, n1;
	logic [7:0]    wrap;

	always_comb begin
		n1   = sgn_s2 & (|p1_s2);
		n10  = sgn_s2 & (|p10_s2);
		fb   = 1'b0;
		wrap = n1 ? (8'd0 - p1_s2[7:0]) : p1_s2[7:0];
		case (kind_s2)
			fwdf_pkg::KIND_U2: msel = MW'(wrap);
			fwdf_pkg::KIND_F3_2U, fwdf_pkg::KIND_F5_2, fwdf_pkg::KIND_F5_2S,
			fwdf_pkg::KIND_F6_2U, fwdf_pkg::KIND_F5_2P: msel = p100_s2;
			fwdf_pkg::KIND_F4_1S, fwdf_pkg::KIND_F5_1S: msel = p10_s2;
			fwdf_pkg::KIND_F1_3: msel = p1000_s2;
			fwdf_pkg::KIND_F3_1: begin
				// out of display range: fall back to the four-place integer
				fb   = n10 ? (p10_s2 > MW'(99)) : (p10_s2 > MW'(999));
				msel = fb ? p1_s2 : p10_s2;
			end
			default: msel = p1_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		m_s3             <= PW'(msel);
		ctl_s3.kind      <= kind_s2;
		ctl_s3.plus_char <= plus_s2;
		ctl_s3.fb        <= fb;
		ctl_s3.nz        <= |msel;
		ctl_s3.neg       <= sgn_s2 & (|msel);
		ctl_s3.ge10      <= msel >= MW'(10);
		ctl_s3.ge100     <= msel >= MW'(100);
		ctl_s3.ge1000    <= msel >= MW'(1000);
		ctl_s3.ge10000   <= msel >= MW'(10000);
		ctl_s3.ge100000  <= msel >= MW'(100000);
	end

	assign out_vld = vld_s3;
	assign m_out   = m_s3;
	assign ctl_out = ctl_s3;

endmodule

/* rtl/fwdf_bcd.sv */
module fwdf_bcd #(
	parameter int NS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_vld,
	input  logic [8*NS-1:0]              m_in,
	input  fwdf_pkg::ctl_t               ctl_in,
	output logic                         out_vld,
	output logic [fwdf_pkg::BCDW-1:0]    bcd_out,
	output fwdf_pkg::ctl_t               ctl_out
);
	localparam int PW = 8 * NS;

	logic                        vld_sn [NS];
	logic [PW-1:0]               rem_sn [NS];
	logic [fwdf_pkg::BCDW-1:0]   bcd_sn [NS];
	fwdf_pkg::ctl_t              ctl_sn [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic                      pv;
		logic [PW-1:0]             pr;
		logic [fwdf_pkg::BCDW-1:0] pb;
		fwdf_pkg::ctl_t            pc;
		logic [fwdf_pkg::BCDW-1:0] nb;

		if (g == 0) begin : g_first
			assign pv = in_vld;
			assign pr = m_in;
			assign pb = '0;
			assign pc = ctl_in;
		end else begin : g_next
			assign pv = vld_sn[g-1];
			assign pr = rem_sn[g-1];
			assign pb = bcd_sn[g-1];
			assign pc = ctl_sn[g-1];
		end

		// eight bits per stage, MSB first
		always_comb begin
			nb = pb;
			for (int i = 0; i < 8; i++) begin
				nb = fwdf_pkg::dd_step(nb, pr[PW-1-i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sn[g] <= 1'b0;
			else vld_sn[g] <= pv;
		end

		always_ff @(posedge clk) begin
			rem_sn[g] <= pr << 8;
			bcd_sn[g] <= nb;
			ctl_sn[g] <= pc;
		end
	end

	assign out_vld = vld_sn[NS-1];
	assign bcd_out = bcd_sn[NS-1];
	assign ctl_out = ctl_sn[NS-1];

endmodule

/* rtl/fwdf_fmt.sv */
module fwdf_fmt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [fwdf_pkg::BCDW-1:0]  bcd,
	input  fwdf_pkg::ctl_t             ctl,
	output logic                       done,
	output logic [2:0]                 first_pos,
	output logic [7:0]                 char_pos0,
	output logic [7:0]                 char_pos1,
	output logic [7:0]                 char_pos2,
	output logic [7:0]                 char_pos3,
	output logic [7:0]                 char_pos4,
	output logic [7:0]                 char_pos5,
	output logic [7:0]                 char_pos6
);
	logic [3:0] d0, d1, d2, d3, d4, d5;
	logic [7:0] c0, c1, c2, c3, c4, c5, c6;
	logic [7:0] sg;
	logic [2:0] st;
	logic       int4;

	assign d0 = bcd[3:0];
	assign d1 = bcd[7:4];
	assign d2 = bcd[11:8];
	assign d3 = bcd[15:12];
	assign d4 = bcd[19:16];
	assign d5 = bcd[23:20];

	always_comb begin
		c0 = '0; c1 = '0; c2 = '0; c3 = '0; c4 = '0; c5 = '0; c6 = '0;
		st = 3'd6;
		sg = ctl.neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_PLUS;
		int4 = (ctl.kind == fwdf_pkg::KIND_I4) ||
		       (ctl.kind == fwdf_pkg::KIND_F3_1 && ctl.fb);
		if (int4) begin
			if (!ctl.neg && ctl.ge1000) begin
				c3 = fwdf_pkg::ch(d3); c4 = fwdf_pkg::ch(d2); c5 = fwdf_pkg::ch(d1);
			end else if (ctl.ge100) begin
				c3 = ctl.neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK;
				c4 = fwdf_pkg::ch(d2); c5 = fwdf_pkg::ch(d1);
			end else begin
				c3 = fwdf_pkg::CH_BLANK;
				if (ctl.ge10) begin
					c4 = ctl.neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK;
					c5 = fwdf_pkg::ch(d1);
				end else begin
					c4 = fwdf_pkg::CH_BLANK;
					c5 = ctl.neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK;
				end
			end
			c6 = fwdf_pkg::ch(d0); st = 3'd3;
		end else begin
			case (ctl.kind)
				fwdf_pkg::KIND_U2: begin
					c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::ch(d0); st = 3'd5;
				end
				fwdf_pkg::KIND_I3: begin
					c4 = ctl.neg ? fwdf_pkg::CH_MINUS :
					     (ctl.ge100 ? fwdf_pkg::ch(d2) : fwdf_pkg::CH_BLANK);
					c5 = ctl.ge10 ? fwdf_pkg::ch(d1) : fwdf_pkg::CH_BLANK;
					c6 = fwdf_pkg::ch(d0); st = 3'd4;
				end
				fwdf_pkg::KIND_ILEFT: begin
					if (ctl.neg) begin
						c6 = fwdf_pkg::CH_ZERO - {4'd0, d0};
					end else begin
						c6 = fwdf_pkg::ch(d0);
						if (ctl.ge10) begin
							c5 = fwdf_pkg::ch(d1); st = 3'd5;
						end
						if (ctl.ge100) begin
							c4 = fwdf_pkg::ch(d2); st = 3'd4;
						end
					end
				end
				fwdf_pkg::KIND_F3_2U: begin
					c3 = fwdf_pkg::ch(d2); c4 = fwdf_pkg::CH_DOT;
					c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::ch(d0); st = 3'd3;
				end
				fwdf_pkg::KIND_F5_2: begin
					c1 = ctl.neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::ch(d4);
					c2 = fwdf_pkg::ch(d3); c3 = fwdf_pkg::ch(d2); c4 = fwdf_pkg::CH_DOT;
					c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::ch(d0); st = 3'd1;
				end
				fwdf_pkg::KIND_F3_1: begin
					c3 = ctl.neg ? fwdf_pkg::CH_MINUS :
					     (ctl.ge100 ? fwdf_pkg::ch(d2) : fwdf_pkg::CH_BLANK);
					c4 = fwdf_pkg::ch(d1); c5 = fwdf_pkg::CH_DOT;
					c6 = fwdf_pkg::ch(d0); st = 3'd3;
				end
				fwdf_pkg::KIND_F4_1S: begin
					c1 = sg; c2 = fwdf_pkg::ch(d3); c3 = fwdf_pkg::ch(d2);
					c4 = fwdf_pkg::ch(d1); c5 = fwdf_pkg::CH_DOT;
					c6 = fwdf_pkg::ch(d0); st = 3'd1;
				end
				fwdf_pkg::KIND_F1_3: begin
					c1 = !ctl.nz ? fwdf_pkg::CH_BLANK :
					     (ctl.neg ? fwdf_pkg::CH_MINUS : ctl.plus_char);
					c2 = fwdf_pkg::ch(d3); c3 = fwdf_pkg::CH_DOT; c4 = fwdf_pkg::ch(d2);
					c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::ch(d0); st = 3'd1;
				end
				fwdf_pkg::KIND_I5: begin
					c2 = ctl.ge10000 ? fwdf_pkg::ch(d4) : fwdf_pkg::CH_BLANK;
					c3 = ctl.ge1000 ? fwdf_pkg::ch(d3) : fwdf_pkg::CH_BLANK;
					c4 = ctl.ge100 ? fwdf_pkg::ch(d2) : fwdf_pkg::CH_BLANK;
					c5 = ctl.ge10 ? fwdf_pkg::ch(d1) : fwdf_pkg::CH_BLANK;
					c6 = fwdf_pkg::ch(d0); st = 3'd2;
				end
				fwdf_pkg::KIND_F5_1S: begin
					c0 = sg; c1 = fwdf_pkg::ch(d4); c2 = fwdf_pkg::ch(d3);
					c3 = fwdf_pkg::ch(d2); c4 = fwdf_pkg::ch(d1); c5 = fwdf_pkg::CH_DOT;
					c6 = fwdf_pkg::ch(d0); st = 3'd0;
				end
				fwdf_pkg::KIND_F5_2S: begin
					c0 = sg; c1 = fwdf_pkg::ch(d4); c2 = fwdf_pkg::ch(d3);
					c3 = fwdf_pkg::ch(d2); c4 = fwdf_pkg::CH_DOT; c5 = fwdf_pkg::ch(d1);
					c6 = fwdf_pkg::ch(d0); st = 3'd0;
				end
				fwdf_pkg::KIND_F6_2U: begin
					c0 = ctl.ge100000 ? fwdf_pkg::ch(d5) : fwdf_pkg::CH_BLANK;
					c1 = ctl.ge10000 ? fwdf_pkg::ch(d4) : fwdf_pkg::CH_BLANK;
					c2 = ctl.ge1000 ? fwdf_pkg::ch(d3) : fwdf_pkg::CH_BLANK;
					c3 = fwdf_pkg::ch(d2); c4 = fwdf_pkg::CH_DOT; c5 = fwdf_pkg::ch(d1);
					c6 = fwdf_pkg::ch(d0); st = 3'd0;
				end
				fwdf_pkg::KIND_F5_2P: begin
					c1 = ctl.neg ? fwdf_pkg::CH_MINUS :
					     (ctl.ge10000 ? fwdf_pkg::ch(d4) : fwdf_pkg::CH_BLANK);
					c2 = ctl.ge1000 ? fwdf_pkg::ch(d3) : fwdf_pkg::CH_BLANK;
					c3 = fwdf_pkg::ch(d2);
					// trim trailing zero decimals
					if (d0 != 4'd0) begin
						c4 = fwdf_pkg::CH_DOT; c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::ch(d0);
					end else if (d1 != 4'd0) begin
						c4 = fwdf_pkg::CH_DOT; c5 = fwdf_pkg::ch(d1); c6 = fwdf_pkg::CH_BLANK;
					end else begin
						c4 = fwdf_pkg::CH_BLANK; c5 = fwdf_pkg::CH_BLANK;
						c6 = fwdf_pkg::CH_BLANK;
					end
					st = 3'd1;
				end
				default: begin
					c6 = fwdf_pkg::CH_BLANK; st = 3'd6;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= in_vld;
	end

	always_ff @(posedge clk) begin
		first_pos <= st;
		char_pos0 <= c0;
		char_pos1 <= c1;
		char_pos2 <= c2;
		char_pos3 <= c3;
		char_pos4 <= c4;
		char_pos5 <= c5;
		char_pos6 <= c6;
	end

endmodule

/* rtl/fixed_width_decimal_formatter.sv */
// Formats a signed fixed-point value into a right-aligned seven-character ASCII
// field in one of fourteen display formats. A new beat is taken every cycle
// (busy stays low). Each result passes through the input, scaling and select
// registers, a register stage for each eight bits of the binary-to-BCD
// conversion, and the character output register before it appears on done. The
// receiver cannot stall, so results must be captured in the cycle done is high.
module fixed_width_decimal_formatter #(
	parameter int FRAC_BITS = fwdf_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         kind,
	input  logic signed [31:0] value,
	input  logic [7:0]         plus_char,
	output logic               done,
	output logic [2:0]         first_pos,
	output logic [7:0]         char_pos0,
	output logic [7:0]         char_pos1,
	output logic [7:0]         char_pos2,
	output logic [7:0]         char_pos3,
	output logic [7:0]         char_pos4,
	output logic [7:0]         char_pos5,
	output logic [7:0]         char_pos6
);
	localparam int NS = (42 - FRAC_BITS + 7) / 8;
	localparam int PW = 8 * NS;

	logic                       sc_vld, dd_vld;
	logic [PW-1:0]              sc_m;
	fwdf_pkg::ctl_t             sc_ctl, dd_ctl;
	logic [fwdf_pkg::BCDW-1:0]  dd_bcd;

	assign busy = 1'b0;

	fwdf_scale #(.FRAC_BITS(FRAC_BITS), .PW(PW)) u_scale (
		.clk(clk), .arst_n(arst_n), .in_vld(start & ~busy),
		.kind(kind), .value(value), .plus_char(plus_char),
		.out_vld(sc_vld), .m_out(sc_m), .ctl_out(sc_ctl)
	);

	fwdf_bcd #(.NS(NS)) u_bcd (
		.clk(clk), .arst_n(arst_n), .in_vld(sc_vld), .m_in(sc_m), .ctl_in(sc_ctl),
		.out_vld(dd_vld), .bcd_out(dd_bcd), .ctl_out(dd_ctl)
	);

	fwdf_fmt u_fmt (
		.clk(clk), .arst_n(arst_n), .in_vld(dd_vld), .bcd(dd_bcd), .ctl(dd_ctl),
		.done(done), .first_pos(first_pos),
		.char_pos0(char_pos0), .char_pos1(char_pos1), .char_pos2(char_pos2),
		.char_pos3(char_pos3), .char_pos4(char_pos4), .char_pos5(char_pos5),
		.char_pos6(char_pos6)
	);

endmodule

/* rtl/fwdf_chk.sv */
module fwdf_chk #(
	parameter int FRAC_BITS = fwdf_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [3:0] kind,
	input logic       done,
	input logic [2:0] first_pos,
	input logic [7:0] char_pos6
);
	localparam int LAT = 4 + (42 - FRAC_BITS + 7) / 8;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, LAT) |-> (done == $past(start & ~busy, LAT)))
		else $error("result beat does not match start beat latency");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (first_pos <= 3'd6 && char_pos6 != 8'd0))
		else $error("bad result field");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(arst_n, LAT) && $past(kind, LAT) > 4'd13)
		|-> (first_pos == 3'd6 && char_pos6 == fwdf_pkg::CH_BLANK))
		else $error("unused format select gave wrong field");

endmodule

bind fixed_width_decimal_formatter fwdf_chk #(.FRAC_BITS(FRAC_BITS)) u_fwdf_chk (.*);

/* dv/tb.sv */
module tb;

	typedef struct packed {
		logic [2:0] first_pos;
		logic [7:0] c0, c1, c2, c3, c4, c5, c6;
	} field_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] kind = fwdf_pkg::KIND_U2;
	logic signed [31:0] value = '0;
	logic [7:0] plus_char = '0;
	logic done;
	logic [2:0] first_pos;
	logic [7:0] char_pos0, char_pos1, char_pos2, char_pos3, char_pos4, char_pos5, char_pos6;

	field_t pending_fields[$];
	int errors = 0;
	int cycles = 0;
	bit idle_on = 1'b1;

	fixed_width_decimal_formatter u_top (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] digit(input logic [63:0] m, input logic [63:0] w);
		return fwdf_pkg::CH_ZERO + 8'((m / w) % 10);
	endfunction

	function automatic logic [7:0] digit_or_blank(input logic [63:0] m, input logic [63:0] w);
		return (m >= w) ? digit(m, w) : fwdf_pkg::CH_BLANK;
	endfunction

	function automatic logic [63:0] scale_trunc(input logic [31:0] v, input logic [63:0] k,
			output logic neg);
		logic [63:0] mag;
		logic [63:0] m;
		mag = v[31] ? {32'd0, (~v + 32'd1)} : {32'd0, v};
		m = (mag * k) >> fwdf_pkg::FRAC_BITS_DEF;
		neg = v[31] && (m != 0);
		return m;
	endfunction

	function automatic void int4_field(ref logic [7:0] c[7], input logic neg,
			input logic [63:0] m);
		if (!neg && m >= 1000) begin
			c[3] = digit(m, 1000); c[4] = digit(m, 100); c[5] = digit(m, 10);
		end else if (m >= 100) begin
			c[3] = neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK;
			c[4] = digit(m, 100); c[5] = digit(m, 10);
		end else begin
			c[3] = fwdf_pkg::CH_BLANK;
			if (m >= 10) begin
				c[4] = neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK; c[5] = digit(m, 10);
			end else begin
				c[4] = fwdf_pkg::CH_BLANK; c[5] = neg ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_BLANK;
			end
		end
		c[6] = digit(m, 1);
	endfunction

	function automatic field_t format_value(input logic [3:0] k, input logic [31:0] v,
			input logic [7:0] pc);
		logic [7:0] c[7];
		logic [2:0] st;
		logic n;
		logic [63:0] m;
		logic [63:0] d;
		field_t r;
		foreach (c[i]) c[i] = 8'd0;
		st = 3'd6;
		case (k)
			fwdf_pkg::KIND_U2: begin
				m = scale_trunc(v, 1, n);
				m = n ? ((256 - (m & 255)) & 255) : (m & 255);
				c[5] = digit(m, 10); c[6] = digit(m, 1); st = 3'd5;
			end
			fwdf_pkg::KIND_I3: begin
				m = scale_trunc(v, 1, n);
				c[4] = n ? fwdf_pkg::CH_MINUS : digit_or_blank(m, 100);
				c[5] = digit_or_blank(m, 10); c[6] = digit(m, 1); st = 3'd4;
			end
			fwdf_pkg::KIND_ILEFT: begin
				m = scale_trunc(v, 1, n);
				if (n) begin
					c[6] = fwdf_pkg::CH_ZERO - 8'(m % 10); st = 3'd6;
				end else begin
					c[6] = digit(m, 1);
					if (m >= 10) begin
						c[5] = digit(m, 10); st = 3'd5;
						if (m >= 100) begin
							c[4] = digit(m, 100); st = 3'd4;
						end
					end
				end
			end
			fwdf_pkg::KIND_I4: begin
				m = scale_trunc(v, 1, n);
				int4_field(c, n, m); st = 3'd3;
			end
			fwdf_pkg::KIND_F3_2U: begin
				m = scale_trunc(v, 100, n);
				c[3] = digit(m, 100); c[4] = fwdf_pkg::CH_DOT; c[5] = digit(m, 10);
				c[6] = digit(m, 1); st = 3'd3;
			end
			fwdf_pkg::KIND_F5_2: begin
				m = scale_trunc(v, 100, n);
				c[1] = n ? fwdf_pkg::CH_MINUS : digit(m, 10000); c[2] = digit(m, 1000);
				c[3] = digit(m, 100); c[4] = fwdf_pkg::CH_DOT; c[5] = digit(m, 10);
				c[6] = digit(m, 1); st = 3'd1;
			end
			fwdf_pkg::KIND_F3_1: begin
				m = scale_trunc(v, 10, n);
				st = 3'd3;
				if (n ? m > 99 : m > 999) begin
					m = scale_trunc(v, 1, n);
					int4_field(c, n, m);
				end else begin
					c[3] = n ? fwdf_pkg::CH_MINUS : digit_or_blank(m, 100);
					c[4] = digit(m, 10); c[5] = fwdf_pkg::CH_DOT; c[6] = digit(m, 1);
				end
			end
			fwdf_pkg::KIND_F4_1S: begin
				m = scale_trunc(v, 10, n);
				c[1] = n ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_PLUS;
				c[2] = digit(m, 1000); c[3] = digit(m, 100);
				c[4] = digit(m, 10); c[5] = fwdf_pkg::CH_DOT; c[6] = digit(m, 1); st = 3'd1;
			end
			fwdf_pkg::KIND_F1_3: begin
				m = scale_trunc(v, 1000, n);
				c[1] = (m != 0) ? (n ? fwdf_pkg::CH_MINUS : pc) : fwdf_pkg::CH_BLANK;
				c[2] = digit(m, 1000); c[3] = fwdf_pkg::CH_DOT; c[4] = digit(m, 100);
				c[5] = digit(m, 10); c[6] = digit(m, 1); st = 3'd1;
			end
			fwdf_pkg::KIND_I5: begin
				m = scale_trunc(v, 1, n);
				c[2] = digit_or_blank(m, 10000); c[3] = digit_or_blank(m, 1000);
				c[4] = digit_or_blank(m, 100); c[5] = digit_or_blank(m, 10);
				c[6] = digit(m, 1); st = 3'd2;
			end
			fwdf_pkg::KIND_F5_1S: begin
				m = scale_trunc(v, 10, n);
				c[0] = n ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_PLUS;
				c[1] = digit(m, 10000); c[2] = digit(m, 1000);
				c[3] = digit(m, 100); c[4] = digit(m, 10); c[5] = fwdf_pkg::CH_DOT;
				c[6] = digit(m, 1); st = 3'd0;
			end
			fwdf_pkg::KIND_F5_2S: begin
				m = scale_trunc(v, 100, n);
				c[0] = n ? fwdf_pkg::CH_MINUS : fwdf_pkg::CH_PLUS;
				c[1] = digit(m, 10000); c[2] = digit(m, 1000);
				c[3] = digit(m, 100); c[4] = fwdf_pkg::CH_DOT; c[5] = digit(m, 10);
				c[6] = digit(m, 1); st = 3'd0;
			end
			fwdf_pkg::KIND_F6_2U: begin
				m = scale_trunc(v, 100, n);
				c[0] = digit_or_blank(m, 100000); c[1] = digit_or_blank(m, 10000);
				c[2] = digit_or_blank(m, 1000); c[3] = digit(m, 100);
				c[4] = fwdf_pkg::CH_DOT;
				c[5] = digit(m, 10); c[6] = digit(m, 1); st = 3'd0;
			end
			fwdf_pkg::KIND_F5_2P: begin
				m = scale_trunc(v, 100, n);
				c[1] = n ? fwdf_pkg::CH_MINUS : digit_or_blank(m, 10000);
				c[2] = digit_or_blank(m, 1000); c[3] = digit(m, 100);
				d = m % 10;
				if (d != 0) begin
					c[4] = fwdf_pkg::CH_DOT; c[5] = digit(m, 10);
					c[6] = fwdf_pkg::CH_ZERO + 8'(d);
				end else begin
					d = (m / 10) % 10;
					if (d != 0) begin
						c[4] = fwdf_pkg::CH_DOT; c[5] = fwdf_pkg::CH_ZERO + 8'(d);
					end else begin
						c[4] = fwdf_pkg::CH_BLANK; c[5] = fwdf_pkg::CH_BLANK;
					end
					c[6] = fwdf_pkg::CH_BLANK;
				end
				st = 3'd1;
			end
			default: begin
				c[6] = fwdf_pkg::CH_BLANK; st = 3'd6;
			end
		endcase
		r = {st, c[0], c[1], c[2], c[3], c[4], c[5], c[6]};
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("tb: mismatch %s got %h want %h", what, got, want);
		errors++;
	endtask

	// check each result beat against the oldest expected field
	always @(posedge clk) begin
		field_t want;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			if (pending_fields.size() == 0) begin
				report_mismatch("done", 8'd1, 8'd0);
			end else begin
				want = pending_fields.pop_front();
				if (first_pos !== want.first_pos)
					report_mismatch("first_pos", {5'd0, first_pos}, {5'd0, want.first_pos});
				if (char_pos0 !== want.c0) report_mismatch("char_pos0", char_pos0, want.c0);
				if (char_pos1 !== want.c1) report_mismatch("char_pos1", char_pos1, want.c1);
				if (char_pos2 !== want.c2) report_mismatch("char_pos2", char_pos2, want.c2);
				if (char_pos3 !== want.c3) report_mismatch("char_pos3", char_pos3, want.c3);
				if (char_pos4 !== want.c4) report_mismatch("char_pos4", char_pos4, want.c4);
				if (char_pos5 !== want.c5) report_mismatch("char_pos5", char_pos5, want.c5);
				if (char_pos6 !== want.c6) report_mismatch("char_pos6", char_pos6, want.c6);
			end
		end
	end

	initial begin
		wait (cycles > 400000);
		$display("tb: failure");
		$finish;
	end

	// send one beat; start stays high across back-to-back beats
	task automatic send_value(input logic [3:0] k, input logic [31:0] v, input logic [7:0] pc);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		value <= v;
		plus_char <= pc;
		do @(posedge clk); while (busy);
		pending_fields.push_back(format_value(k, v, pc));
	endtask

	// drop start before the next edge so the last beat is not taken again
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending_fields.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes;
		logic [31:0] edge_vals[10] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF,
			32'h0001_0000, 32'hFFFF_0000, 32'hFC18_0000, 32'h03E8_0000, 32'h0000_0A3D,
			32'hFF9C_0000};
		for (int k = 0; k < 16; k++)
			send_value(4'(k), edge_vals[k % 10], 8'(k * 17));
		for (int i = 0; i < 10; i++)
			send_value(fwdf_pkg::KIND_F3_1, edge_vals[i], fwdf_pkg::CH_PLUS);
	endtask

	task automatic test_random_values;
		logic [31:0] v;
		for (int i = 0; i < 1000; i++) begin
			case ($urandom_range(0, 3))
				0: v = $urandom;
				1: v = 32'($signed($urandom_range(0, 2000000)) - 1000000);
				2: v = 32'($signed($urandom_range(0, 200000)) - 100000) <<< 16;
				default: v = 32'($signed($urandom_range(0, 2000)) - 1000);
			endcase
			send_value(4'($urandom_range(0, 15)), v, 8'($urandom));
			if (i == 500) drain;
		end
	endtask

	task automatic test_back_to_back;
		idle_on = 1'b0;
		for (int i = 0; i < 300; i++)
			send_value(4'($urandom_range(0, 13)), $urandom, 8'($urandom));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_random_values();
		test_back_to_back();
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
